[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file of the project.
// Needs a signal named clk, and arst_n for LQFC_ASSERT, in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LQFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LQFC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/lqfc_pkg.sv]
// Types and constants of the link quality flow control block.
// No dependencies; used by every module of the block.
`default_nettype none

package lqfc_pkg;

	localparam int unsigned TICK_W  = 10;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned RATE_W  = 8;
	localparam int unsigned EVENT_W = 2;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned OUT_W   = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_TICK_MS      = 3'd0,
		REG_RTT_THRESH   = 3'd1,
		REG_INIT_PENALTY = 3'd2,
		REG_MIN_PENALTY  = 3'd3,
		REG_MAX_PENALTY  = 3'd4,
		REG_STABLE_WIN   = 3'd5,
		REG_GOOD_RATE    = 3'd6,
		REG_BAD_RATE     = 3'd7
	} reg_idx_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE    = 2'd0,
		EV_DROP    = 2'd1,
		EV_UPGRADE = 2'd2
	} mode_event_t;

	typedef enum logic {
		REQ_TICK    = 1'b0,
		REQ_RESTART = 1'b1
	} req_type_t;

	localparam logic [TICK_W-1:0] TICK_MS_RST      = 10'd33;
	localparam logic [MS_W-1:0]   RTT_THRESH_RST   = 16'd250;
	localparam logic [MS_W-1:0]   INIT_PENALTY_RST = 16'd4000;
	localparam logic [MS_W-1:0]   MIN_PENALTY_RST  = 16'd1000;
	localparam logic [MS_W-1:0]   MAX_PENALTY_RST  = 16'd60000;
	localparam logic [MS_W-1:0]   STABLE_WIN_RST   = 16'd10000;
	localparam logic [RATE_W-1:0] GOOD_RATE_RST    = 8'd30;
	localparam logic [RATE_W-1:0] BAD_RATE_RST     = 8'd10;

	typedef struct packed {
		logic [TICK_W-1:0] tick_ms;
		logic [MS_W-1:0]   rtt_threshold_ms;
		logic [MS_W-1:0]   initial_penalty_ms;
		logic [MS_W-1:0]   min_penalty_ms;
		logic [MS_W-1:0]   max_penalty_ms;
		logic [MS_W-1:0]   stable_window_ms;
		logic [RATE_W-1:0] good_rate;
		logic [RATE_W-1:0] bad_rate;
	} cfg_t;

	typedef struct packed {
		mode_event_t       mode_event;
		logic [MS_W-1:0]   penalty_ms;
		logic [RATE_W-1:0] send_rate;
		logic              good_mode;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/lqfc_cfg_regs.sv]
// Configuration register file of the link quality flow control block.
// Depends on lqfc_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module lqfc_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [lqfc_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [lqfc_pkg::MS_W-1:0]    wr_data,
	output lqfc_pkg::cfg_t                    cfg
);

	lqfc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_ms            <= lqfc_pkg::TICK_MS_RST;
			cfg_q.rtt_threshold_ms   <= lqfc_pkg::RTT_THRESH_RST;
			cfg_q.initial_penalty_ms <= lqfc_pkg::INIT_PENALTY_RST;
			cfg_q.min_penalty_ms     <= lqfc_pkg::MIN_PENALTY_RST;
			cfg_q.max_penalty_ms     <= lqfc_pkg::MAX_PENALTY_RST;
			cfg_q.stable_window_ms   <= lqfc_pkg::STABLE_WIN_RST;
			cfg_q.good_rate          <= lqfc_pkg::GOOD_RATE_RST;
			cfg_q.bad_rate           <= lqfc_pkg::BAD_RATE_RST;
		end else if (wr_en) begin
			unique case (lqfc_pkg::reg_idx_t'(wr_index))
				lqfc_pkg::REG_TICK_MS:      cfg_q.tick_ms <= wr_data[lqfc_pkg::TICK_W-1:0];
				lqfc_pkg::REG_RTT_THRESH:   cfg_q.rtt_threshold_ms <= wr_data;
				lqfc_pkg::REG_INIT_PENALTY: cfg_q.initial_penalty_ms <= wr_data;
				lqfc_pkg::REG_MIN_PENALTY:  cfg_q.min_penalty_ms <= wr_data;
				lqfc_pkg::REG_MAX_PENALTY:  cfg_q.max_penalty_ms <= wr_data;
				lqfc_pkg::REG_STABLE_WIN:   cfg_q.stable_window_ms <= wr_data;
				lqfc_pkg::REG_GOOD_RATE:    cfg_q.good_rate <= wr_data[lqfc_pkg::RATE_W-1:0];
				lqfc_pkg::REG_BAD_RATE:     cfg_q.bad_rate <= wr_data[lqfc_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/lqfc_core.sv]
// Mode, penalty and time accumulator state with its combinational update.
// Depends on lqfc_pkg for cfg_t, res_t and the event and request codes.
`default_nettype none

module lqfc_core #(
	parameter int unsigned TIME_BITS = 24
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       req_type,
	input  wire logic [lqfc_pkg::MS_W-1:0]  rtt_ms,
	input  lqfc_pkg::cfg_t                  cfg,
	output lqfc_pkg::res_t                  res
);

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	logic                      mode_good_q;
	logic [lqfc_pkg::MS_W-1:0] penalty_q;
	logic [TIME_BITS-1:0]      good_time_q;
	logic [TIME_BITS-1:0]      red_time_q;

	logic                      mode_good_d;
	logic [lqfc_pkg::MS_W-1:0] penalty_d;
	logic [TIME_BITS-1:0]      good_time_d;
	logic [TIME_BITS-1:0]      red_time_d;
	lqfc_pkg::mode_event_t     event_d;

	logic                      above;
	logic [TIME_BITS:0]        good_sum;
	logic [TIME_BITS:0]        red_sum;
	logic [TIME_BITS-1:0]      good_sat;
	logic [TIME_BITS-1:0]      red_sat;
	logic [TIME_BITS-1:0]      good_bad;
	logic [TIME_BITS-1:0]      window_ext;
	logic [TIME_BITS-1:0]      penalty_ext;
	logic [lqfc_pkg::MS_W:0]   doubled;
	logic [lqfc_pkg::MS_W-1:0] halved;

	assign above       = rtt_ms > cfg.rtt_threshold_ms;
	assign good_sum    = {1'b0, good_time_q}
		+ {{(TIME_BITS + 1 - lqfc_pkg::TICK_W){1'b0}}, cfg.tick_ms};
	assign red_sum     = {1'b0, red_time_q}
		+ {{(TIME_BITS + 1 - lqfc_pkg::TICK_W){1'b0}}, cfg.tick_ms};
	assign good_sat    = good_sum[TIME_BITS] ? TIME_MAX : good_sum[TIME_BITS-1:0];
	assign red_sat     = red_sum[TIME_BITS] ? TIME_MAX : red_sum[TIME_BITS-1:0];
	assign good_bad    = above ? '0 : good_sat;
	assign window_ext  = {{(TIME_BITS - lqfc_pkg::MS_W){1'b0}}, cfg.stable_window_ms};
	assign penalty_ext = {{(TIME_BITS - lqfc_pkg::MS_W){1'b0}}, penalty_q};
	assign doubled     = {penalty_q, 1'b0};
	assign halved      = {1'b0, penalty_q[lqfc_pkg::MS_W-1:1]};

	always_comb begin
		mode_good_d = mode_good_q;
		penalty_d   = penalty_q;
		good_time_d = good_time_q;
		red_time_d  = red_time_q;
		event_d     = lqfc_pkg::EV_NONE;
		if (req_type == lqfc_pkg::REQ_RESTART) begin
			mode_good_d = 1'b0;
			penalty_d   = cfg.initial_penalty_ms;
			good_time_d = '0;
			red_time_d  = '0;
		end else if (mode_good_q) begin
			if (above) begin
				// drop to bad; a short good streak doubles the penalty, capped at the maximum
				mode_good_d = 1'b0;
				if (good_time_q < window_ext && penalty_q < cfg.max_penalty_ms) begin
					penalty_d = (doubled > {1'b0, cfg.max_penalty_ms})
						? cfg.max_penalty_ms : doubled[lqfc_pkg::MS_W-1:0];
				end
				good_time_d = '0;
				red_time_d  = '0;
				event_d     = lqfc_pkg::EV_DROP;
			end else begin
				good_time_d = good_sat;
				red_time_d  = red_sat;
				if (red_sat > window_ext && penalty_q > cfg.min_penalty_ms) begin
					penalty_d  = (halved < cfg.min_penalty_ms) ? cfg.min_penalty_ms : halved;
					red_time_d = '0;
				end
			end
		end else begin
			good_time_d = good_bad;
			if (good_bad > penalty_ext) begin
				good_time_d = '0;
				red_time_d  = '0;
				mode_good_d = 1'b1;
				event_d     = lqfc_pkg::EV_UPGRADE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_good_q <= 1'b0;
			penalty_q   <= lqfc_pkg::INIT_PENALTY_RST;
			good_time_q <= '0;
			red_time_q  <= '0;
		end else if (adv) begin
			mode_good_q <= mode_good_d;
			penalty_q   <= penalty_d;
			good_time_q <= good_time_d;
			red_time_q  <= red_time_d;
		end
	end

	assign res.good_mode  = mode_good_d;
	assign res.send_rate  = mode_good_d ? cfg.good_rate : cfg.bad_rate;
	assign res.penalty_ms = penalty_d;
	assign res.mode_event = event_d;

endmodule

`default_nettype wire

[hw/rtl/link_quality_flow_control.sv]
// Link quality flow control: good/bad mode tracking with penalty backoff.
// Input beats on s_*: tuser carries req_type (tick or restart), tdata the
// measured round-trip time. Every input beat yields exactly one output beat on
// m_*, showing mode, send rate, penalty and the mode change of that tick.
// Configuration goes through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high, and registers are meant to change only while the block is idle.
// An input beat passes the input register, then the result register fed by the
// combinational state update.
// Throughput: one beat per cycle while m_tready is high; the state update is
// combinational, so consecutive beats see each other's results with no bubble.
// When m_tready is low the result register holds and the input register
// still takes one more beat; s_tready then falls until the result drains.
// Reset (arst_n low) clears both registers' valid flags, returns the mode to
// bad, the penalty to 4000 ms, the accumulators to zero and the configuration
// registers to their defaults. A restart beat reloads the state likewise,
// using the current initial penalty register.
// Depends on lqfc_pkg, lqfc_cfg_regs and lqfc_core.
`default_nettype none

module link_quality_flow_control #(
	parameter int unsigned TIME_BITS = 24
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output      logic                        s_tready,
	input  wire logic [lqfc_pkg::MS_W-1:0]   s_tdata,   // [15:0] rtt_ms
	input  wire logic                        s_tuser,   // [0] req_type
	output      logic                        m_tvalid,
	input  wire logic                        m_tready,
	// [0] good_mode, [8:1] send_rate, [24:9] penalty_ms, [26:25] mode_event, rest 0
	output      logic [lqfc_pkg::OUT_W-1:0]  m_tdata,
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [lqfc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [lqfc_pkg::MS_W-1:0]   cfg_data
);

	localparam int unsigned RES_W = $bits(lqfc_pkg::res_t);

	lqfc_pkg::cfg_t            cfg;
	lqfc_pkg::res_t            res;

	logic                      valid_s1;
	logic                      req_s1;
	logic [lqfc_pkg::MS_W-1:0] rtt_s1;
	logic                      out_valid_q;
	logic [lqfc_pkg::OUT_W-1:0] out_data_q;
	logic                      adv;

	assign cfg_ready = 1'b1;

	lqfc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// advance when the input register holds a beat and the result register is free or drains this cycle
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= s_tuser;
			rtt_s1 <= s_tdata;
		end
	end

	lqfc_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.req_type (req_s1),
		.rtt_ms   (rtt_s1),
		.cfg      (cfg),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {{(lqfc_pkg::OUT_W - RES_W){1'b0}}, res};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

[hw/rtl/lqfc_checker.sv]
// Port-level checks for link_quality_flow_control, bound to the top level.
// Depends on lqfc_pkg and the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lqfc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tready,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [lqfc_pkg::OUT_W-1:0]  m_tdata
);

	`LQFC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")
	`LQFC_ASSERT(a_drop_bad, m_tvalid && m_tdata[26:25] == lqfc_pkg::EV_DROP |-> !m_tdata[0], "drop event with good mode set")
	`LQFC_ASSERT(a_up_good, m_tvalid && m_tdata[26:25] == lqfc_pkg::EV_UPGRADE |-> m_tdata[0], "upgrade event with bad mode")
	`LQFC_ASSERT(a_ready_idle, !m_tvalid |-> s_tready, "input stalled with empty output")
	`LQFC_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind link_quality_flow_control lqfc_checker u_lqfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
